// ===== hw/rtl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types and constants for the adsr envelope with slew limiter
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int CFG_T_W   = 21;
    localparam int LVL_W     = 16;
    localparam int SHAPE_W   = 17;
    localparam int REL_W     = 32;
    localparam int MUL_A_W   = 21;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = 38;
    localparam int ROOT_W    = 16;
    localparam int RAD_W     = 32;
    localparam int SQRT_CNT_W = 5;

    localparam logic [SHAPE_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [SHAPE_W-1:0] NO_NOTE   = 17'h1FFFF;
    localparam logic [LVL_W-1:0]   SLEW_STEP = 16'd655;

    localparam logic [CFG_T_W-1:0] ATTACK_RST  = 21'd4800;
    localparam logic [CFG_T_W-1:0] DECAY_RST   = 21'd19200;
    localparam logic [LVL_W-1:0]   SUSTAIN_RST = 16'd39322;
    localparam logic [CFG_T_W-1:0] RELEASE_RST = 21'd38400;

    // configuration register indexes
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    // envelope shape cases
    localparam logic [1:0] SHAPE_ONE     = 2'd0;
    localparam logic [1:0] SHAPE_ATT_DIV = 2'd1;
    localparam logic [1:0] SHAPE_SUS     = 2'd2;
    localparam logic [1:0] SHAPE_DEC_DIV = 2'd3;

    // multiplier operations
    localparam logic [1:0] MUL_NONE = 2'd0;
    localparam logic [1:0] MUL_DEC  = 2'd1;
    localparam logic [1:0] MUL_LVL  = 2'd2;
    localparam logic [1:0] MUL_TGT  = 2'd3;

    // divider operations
    localparam logic [1:0] DIV_NONE = 2'd0;
    localparam logic [1:0] DIV_ATT  = 2'd1;
    localparam logic [1:0] DIV_DEC  = 2'd2;
    localparam logic [1:0] DIV_REL  = 2'd3;

    typedef struct packed {
        logic       load_in;
        logic [1:0] mul_op;
        logic [1:0] div_op;
        logic       shape_fix;
        logic       shape_div;
        logic       tick;
        logic       rel_load;
        logic       step_div;
        logic       apply;
        logic       rel_dec;
        logic       tgt_prod;
        logic       slew;
        logic       sqrt_start;
        logic       out_load;
    } adsr_cmd_t;

    typedef struct packed {
        logic [1:0] shape_kind;
        logic       changed;
        logic       amp_zero;
        logic       rel_zero;
        logic       rel_len_zero;
        logic       div_done;
        logic       sqrt_done;
        logic       out_free;
    } adsr_status_t;

endpackage

// ===== hw/rtl/adsr_div.sv =====
// ----------------------------------------------------------------------------
// adsr_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module adsr_div #(
    parameter int NUM_W = 38
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NUM_W-1:0]            num,
    input  logic [adsr_pkg::CFG_T_W-1:0] den,
    output logic [NUM_W-1:0]            quot,
    output logic [adsr_pkg::CFG_T_W-1:0] rem,
    output logic                        done
);
    import adsr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   q_reg;
    logic [CFG_T_W-1:0] r_reg;
    logic [CFG_T_W-1:0] den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CFG_T_W:0]   shifted;
    logic               ge;
    logic [CFG_T_W:0]   diff;

    assign shifted = {r_reg, q_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            r_reg   <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NUM_W-2:0], ge};
            r_reg <= ge ? diff[CFG_T_W-1:0] : shifted[CFG_T_W-1:0];
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/adsr_sqrt.sv =====
// ----------------------------------------------------------------------------
// adsr_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module adsr_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [adsr_pkg::RAD_W-1:0]  radicand,
    output logic [adsr_pkg::ROOT_W-1:0] root,
    output logic                        done
);
    import adsr_pkg::*;

    logic [RAD_W-1:0]      x_reg;
    logic [ROOT_W:0]       rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_W+2:0]     trial_rem;
    logic [ROOT_W+2:0]     trial;
    logic                  ge;
    logic [ROOT_W+2:0]     diff;

    assign trial_rem = {rem_reg, x_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign ge        = trial_rem >= trial;
    assign diff      = trial_rem - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == SQRT_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - SQRT_CNT_W'(1);
                if (cnt_reg == SQRT_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[ROOT_W:0] : trial_rem[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/adsr_dp.sv =====
// ----------------------------------------------------------------------------
// adsr_dp
// datapath: configuration, envelope state, shared multiplier, divider, root
// ----------------------------------------------------------------------------
module adsr_dp #(
    parameter int TIME_BITS = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  adsr_pkg::adsr_cmd_t           cmd,
    output adsr_pkg::adsr_status_t        status,
    input  logic [adsr_pkg::LVL_W-1:0]    amplitude,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [adsr_pkg::CFG_T_W-1:0]  cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [adsr_pkg::LVL_W-1:0]    envelope_out
);
    import adsr_pkg::*;

    localparam int CMP_W = (TIME_BITS > CFG_T_W) ? TIME_BITS : CFG_T_W;
    localparam int NUM_W = (TIME_BITS + 16 > PROD_W) ? TIME_BITS + 16 : PROD_W;

    logic [CFG_T_W-1:0]   att_reg;
    logic [CFG_T_W-1:0]   dec_reg;
    logic [LVL_W-1:0]     sus_reg;
    logic [CFG_T_W-1:0]   rls_reg;
    logic [LVL_W-1:0]     amp_reg;
    logic [SHAPE_W-1:0]   last_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [SHAPE_W-1:0]   shape_reg;
    logic [REL_W-1:0]     rl_reg;
    logic [REL_W-1:0]     step_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [LVL_W-1:0]     tgt_reg;
    logic [LVL_W-1:0]     sm_reg;
    logic [LVL_W-1:0]     out_reg;
    logic                 out_valid_reg;

    logic [CMP_W-1:0]     t_ext;
    logic [CMP_W-1:0]     a_ext;
    logic [CMP_W-1:0]     d_ext;
    logic [CMP_W-1:0]     u;
    logic [CMP_W-1:0]     dmu;
    logic [1:0]           kind;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [NUM_W-1:0]     div_num;
    logic [CFG_T_W-1:0]   div_den;
    logic [NUM_W-1:0]     quot;
    logic [CFG_T_W-1:0]   rem;
    logic                 div_done;
    logic [ROOT_W-1:0]    root;
    logic                 sqrt_done;
    logic                 changed;
    logic [REL_W-1:0]     rl_new;
    logic [LVL_W-1:0]     diff;
    logic [LVL_W-1:0]     sm_next;

    assign t_ext = CMP_W'(elapsed_reg);
    assign a_ext = CMP_W'(att_reg);
    assign d_ext = CMP_W'(dec_reg);
    assign u     = t_ext - a_ext;
    assign dmu   = d_ext - u;

    always_comb
    begin
        if (t_ext <= a_ext)
        begin
            kind = (att_reg == '0) ? SHAPE_ONE : SHAPE_ATT_DIV;
        end
        else if ((dec_reg == '0) || (u > d_ext))
        begin
            kind = SHAPE_SUS;
        end
        else
        begin
            kind = SHAPE_DEC_DIV;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            MUL_DEC:
            begin
                mul_a = dmu[MUL_A_W-1:0];
                mul_b = ONE_Q16 - {1'b0, sus_reg};
            end
            MUL_LVL:
            begin
                mul_a = (last_reg == NO_NOTE) ? '0 : MUL_A_W'(last_reg[LVL_W-1:0]);
                mul_b = shape_reg;
            end
            MUL_TGT:
            begin
                mul_a = MUL_A_W'(amp_reg);
                mul_b = shape_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.div_op)
            DIV_ATT:
            begin
                div_num = NUM_W'({elapsed_reg, 16'h0000});
                div_den = att_reg;
            end
            DIV_DEC:
            begin
                div_num = NUM_W'(prod_reg);
                div_den = dec_reg;
            end
            DIV_REL:
            begin
                div_num = NUM_W'(prod_reg[REL_W-1:0]);
                div_den = rls_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    adsr_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_op != DIV_NONE),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .rem   (rem),
        .done  (div_done)
    );

    adsr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand ({sm_reg, 16'h0000}),
        .root     (root),
        .done     (sqrt_done)
    );

    assign changed = {1'b0, amp_reg} != last_reg;
    assign rl_new  = (rl_reg > step_reg) ? rl_reg - step_reg : '0;

    // slew limiter
    always_comb
    begin
        diff = (tgt_reg > sm_reg) ? tgt_reg - sm_reg : sm_reg - tgt_reg;
        if (diff < SLEW_STEP)
        begin
            sm_next = tgt_reg;
        end
        else if (tgt_reg < sm_reg)
        begin
            sm_next = sm_reg - SLEW_STEP;
        end
        else
        begin
            sm_next = sm_reg + SLEW_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_reg       <= ATTACK_RST;
            dec_reg       <= DECAY_RST;
            sus_reg       <= SUSTAIN_RST;
            rls_reg       <= RELEASE_RST;
            last_reg      <= NO_NOTE;
            elapsed_reg   <= '0;
            rl_reg        <= '0;
            sm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ATTACK:  att_reg <= cfg_data;
                    REG_DECAY:   dec_reg <= cfg_data;
                    REG_SUSTAIN: sus_reg <= cfg_data[LVL_W-1:0];
                    REG_RELEASE: rls_reg <= cfg_data;
                    default:     att_reg <= att_reg;
                endcase
            end

            if (cmd.tick && (elapsed_reg != '1))
            begin
                elapsed_reg <= elapsed_reg + TIME_BITS'(1);
            end

            if (cmd.rel_load)
            begin
                rl_reg <= prod_reg[REL_W-1:0];
            end

            if (cmd.apply && changed)
            begin
                last_reg <= {1'b0, amp_reg};
                if ((amp_reg != '0) || (rl_reg == '0))
                begin
                    elapsed_reg <= '0;
                    rl_reg      <= '0;
                end
            end

            if (cmd.rel_dec)
            begin
                rl_reg <= rl_new;
            end

            if (cmd.slew)
            begin
                sm_reg <= sm_next;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            amp_reg <= amplitude;
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.shape_fix)
        begin
            shape_reg <= (kind == SHAPE_ONE) ? ONE_Q16 : {1'b0, sus_reg};
        end
        else if (cmd.shape_div)
        begin
            shape_reg <= (kind == SHAPE_DEC_DIV) ? {1'b0, sus_reg} + quot[SHAPE_W-1:0]
                                                : quot[SHAPE_W-1:0];
        end
        else if (cmd.apply && changed && ((amp_reg != '0) || (rl_reg == '0)))
        begin
            shape_reg <= (att_reg == '0) ? ONE_Q16 : '0;
        end
        if (cmd.rel_load && (rls_reg == '0))
        begin
            step_reg <= prod_reg[REL_W-1:0];
        end
        else if (cmd.step_div)
        begin
            // round the per-sample step up
            step_reg <= quot[REL_W-1:0] + REL_W'(rem != '0);
        end
        if (cmd.rel_dec)
        begin
            tgt_reg <= rl_new[REL_W-1:REL_W-LVL_W];
        end
        else if (cmd.tgt_prod)
        begin
            tgt_reg <= prod_reg[REL_W-1:REL_W-LVL_W];
        end
        if (cmd.out_load)
        begin
            out_reg <= root;
        end
    end

    assign status.shape_kind   = kind;
    assign status.changed      = changed;
    assign status.amp_zero     = amp_reg == '0;
    assign status.rel_zero     = rl_reg == '0;
    assign status.rel_len_zero = rls_reg == '0;
    assign status.div_done     = div_done;
    assign status.sqrt_done    = sqrt_done;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign envelope_out = out_reg;

endmodule

// ===== hw/rtl/adsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// adsr_ctrl
// controller state machine sequencing one envelope sample through the datapath
// ----------------------------------------------------------------------------
module adsr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  adsr_pkg::adsr_status_t status,
    output adsr_pkg::adsr_cmd_t    cmd
);
    import adsr_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SHAPE     = 4'd1;
    localparam logic [3:0] ST_MUL_DEC   = 4'd2;
    localparam logic [3:0] ST_DIV_SHAPE = 4'd3;
    localparam logic [3:0] ST_UPDATE    = 4'd4;
    localparam logic [3:0] ST_REL_START = 4'd5;
    localparam logic [3:0] ST_DIV_REL   = 4'd6;
    localparam logic [3:0] ST_APPLY     = 4'd7;
    localparam logic [3:0] ST_TARGET    = 4'd8;
    localparam logic [3:0] ST_TGT_MUL   = 4'd9;
    localparam logic [3:0] ST_SLEW      = 4'd10;
    localparam logic [3:0] ST_SQRT_GO   = 4'd11;
    localparam logic [3:0] ST_SQRT      = 4'd12;
    localparam logic [3:0] ST_OUT       = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SHAPE;
                end
            end
            ST_SHAPE:
            begin
                case (status.shape_kind)
                    SHAPE_ATT_DIV:
                    begin
                        cmd.div_op = DIV_ATT;
                        state_next = ST_DIV_SHAPE;
                    end
                    SHAPE_DEC_DIV:
                    begin
                        cmd.mul_op = MUL_DEC;
                        state_next = ST_MUL_DEC;
                    end
                    default:
                    begin
                        cmd.shape_fix = 1'b1;
                        state_next    = ST_UPDATE;
                    end
                endcase
            end
            ST_MUL_DEC:
            begin
                cmd.div_op = DIV_DEC;
                state_next = ST_DIV_SHAPE;
            end
            ST_DIV_SHAPE:
            begin
                if (status.div_done)
                begin
                    cmd.shape_div = 1'b1;
                    state_next    = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.tick = 1'b1;
                // note off starts a release from the current level
                if (status.changed && status.amp_zero)
                begin
                    cmd.mul_op = MUL_LVL;
                    state_next = ST_REL_START;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_REL_START:
            begin
                cmd.rel_load = 1'b1;
                if (status.rel_len_zero)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cmd.div_op = DIV_REL;
                    state_next = ST_DIV_REL;
                end
            end
            ST_DIV_REL:
            begin
                if (status.div_done)
                begin
                    cmd.step_div = 1'b1;
                    state_next   = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_TARGET;
            end
            ST_TARGET:
            begin
                if (!status.rel_zero)
                begin
                    cmd.rel_dec = 1'b1;
                    state_next  = ST_SLEW;
                end
                else
                begin
                    cmd.mul_op = MUL_TGT;
                    state_next = ST_TGT_MUL;
                end
            end
            ST_TGT_MUL:
            begin
                cmd.tgt_prod = 1'b1;
                state_next   = ST_SLEW;
            end
            ST_SLEW:
            begin
                cmd.slew   = 1'b1;
                state_next = ST_SQRT_GO;
            end
            ST_SQRT_GO:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule

// ===== hw/rtl/adsr_envelope_with_slew.sv =====
// timing: set by the shared bit-serial divider (quotient width 38 at TIME_BITS up to 22,
//   TIME_BITS+16 above, up to two divisions per sample) and the bit-serial square root;
//   a finished sample waits in the output state until the output is free
// throughput: one sample at a time, the next is taken once the result is registered
// reset: rst_n is asynchronous, active low; control and configuration registers return to
//   their defaults, the envelope restarts with no note and a zero smoothed level
// ----------------------------------------------------------------------------
// adsr_envelope_with_slew
// adsr envelope with slew limiter and square-root shaping, one sample per item
// ----------------------------------------------------------------------------
module adsr_envelope_with_slew #(
    parameter int TIME_BITS = 21
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] amplitude
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] envelope_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data
);
    import adsr_pkg::*;

    adsr_cmd_t    cmd;
    adsr_status_t status;

    adsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adsr_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .amplitude    (s_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .envelope_out (m_axis_tdata)
    );

    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // one sample in flight: a new transaction closes the input side
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a sample is in flight");

    // a fresh result is only produced while a sample is in flight
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared with no sample in flight");
`endif

endmodule
